/* rtl/core/hmb_pkg.sv */
// hmb_pkg: shared constants for the heightmap mip pyramid builder.
// Holds stream widths, request and status codes and parameter defaults.
// No dependencies.
`default_nettype none

package hmb_pkg;

    localparam int DEFAULT_MAX_MAP_SIZE = 256;
    localparam int DEFAULT_FRAC_BITS    = 16;

    localparam int          MAP_SIZE_W     = 9;
    localparam logic [8:0]  MAP_SIZE_RESET = 9'd256;

    // input request stream
    localparam int IN_TDATA_W = 56;
    localparam int IN_TUSER_W = 2;
    // result stream
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    // request kinds
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_REBUILD = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // result status
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_WINDOW    = 2'd2;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/heightmap_mipmap_builder_core.sv */
// Loads and rejected requests answer in the cycle after acceptance, texel reads once the
// pyramid RAM data returns. A rebuild first divides out the four level 0 window edges
// serially, then weights four source corners per level 0 texel on the shared multiplier and
// averages four parents per further-level texel over the one pyramid RAM read port. One
// request at a time: s_axis_tready is low while busy or while a result waits. Async rst_n:
// map_size 256, pyramid not built, RAMs not cleared. Depends on hmb_pkg and hmb_ram.
`default_nettype none

module heightmap_mipmap_builder_core #(
    parameter int MAX_MAP_SIZE = hmb_pkg::DEFAULT_MAX_MAP_SIZE,
    parameter int FRAC_BITS    = hmb_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration: map_size
    input  wire logic                            cfg_wr_en,
    input  wire logic [hmb_pkg::MAP_SIZE_W-1:0]  cfg_wr_data,
    // requests
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // coord_x[7:0], coord_z[15:8], window_right[24:16], window_top[33:25],
    // level[36:34], height[52:37], zero[55:53]
    input  wire logic [hmb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  wire logic [hmb_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // results
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // read_height[15:0], level_count[19:16], zero[23:20]
    output      logic [hmb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output      logic [hmb_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int MW        = $clog2(MAX_MAP_SIZE + 1);       // map size / coordinate width
    localparam int CW        = (MW > 9) ? MW : 9;              // compare width vs. 9-bit fields
    localparam int SRC_DEPTH = MAX_MAP_SIZE * MAX_MAP_SIZE;
    localparam int SAW       = $clog2(SRC_DEPTH);
    localparam int PYR_DEPTH = (4 * MAX_MAP_SIZE * MAX_MAP_SIZE) / 3;
    localparam int PAW       = $clog2(PYR_DEPTH);
    localparam int NUMW      = 2 * MW + 1;                     // divider dividend width
    localparam int DCW       = $clog2(NUMW + 1);
    localparam int ONE_W     = FRAC_BITS + 1;
    localparam int MA        = 2 * FRAC_BITS + 2;              // multiplier operand A
    localparam int MB        = (ONE_W > 16) ? ONE_W : 16;      // multiplier operand B
    localparam int PW        = MA + MB;
    localparam int SXW       = 2 * MW;
    localparam int XQW       = SXW + FRAC_BITS;
    localparam int ACCW      = 2 * FRAC_BITS + 18;
    localparam int RBW       = 2 * MW + 1;

    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

    // window register slots
    localparam logic [1:0] WIN_L = 2'd0;
    localparam logic [1:0] WIN_B = 2'd1;
    localparam logic [1:0] WIN_R = 2'd2;
    localparam logic [1:0] WIN_T = 2'd3;

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_DLD  = 15'b000000000000010,  // load dividend
        ST_DIT  = 15'b000000000000100,  // one quotient bit per cycle
        ST_DST  = 15'b000000000001000,  // clamp and store window edge
        ST_L0X  = 15'b000000000010000,  // dx * m
        ST_L0Z  = 15'b000000000100000,  // dz * m, latch x source/fraction
        ST_L0F  = 15'b000000001000000,  // latch z source/fraction
        ST_L0W  = 15'b000000010000000,  // corner weight, issue source read
        ST_L0P  = 15'b000000100000000,  // weight * sample
        ST_L0A  = 15'b000001000000000,  // accumulate
        ST_L0WR = 15'b000010000000000,  // write level 0 texel
        ST_HRD  = 15'b000100000000000,  // issue parent read
        ST_HAC  = 15'b001000000000000,  // add parent texel
        ST_HWR  = 15'b010000000000000,  // write averaged texel
        ST_RDW  = 15'b100000000000000   // texel read data returns
    } state_t;

    // ---------------- registers ----------------
    state_t                  state_reg, state_next;
    logic [8:0]              map_size_reg, map_size_next;
    logic                    pyr_valid_reg, pyr_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [15:0]             out_height_reg, out_height_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic [3:0]              out_count_reg, out_count_next;

    logic [1:0]              k_reg, k_next;          // corner / divide step
    logic [3:0]              lvl_reg, lvl_next;
    logic [3:0]              slog_reg, slog_next;    // log2 of current side
    logic [PAW-1:0]          base_reg, base_next;
    logic [PAW-1:0]          pbase_reg, pbase_next;
    logic [MW-1:0]           win_reg [4];
    logic [MW-1:0]           win_next [4];
    logic [MW-1:0]           dx_reg, dx_next;
    logic [MW-1:0]           dz_reg, dz_next;
    logic [MW-1:0]           sx_reg, sx_next;
    logic [MW-1:0]           sz_reg, sz_next;
    logic [ONE_W-1:0]        fx_reg, fx_next;
    logic [ONE_W-1:0]        fz_reg, fz_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [ACCW-1:0]         acc_reg, acc_next;
    logic [17:0]             sum_reg, sum_next;
    logic [NUMW-1:0]         div_num_reg, div_num_next;
    logic [MW-1:0]           rem_reg, rem_next;
    logic [DCW-1:0]          div_cnt_reg, div_cnt_next;

    // ---------------- RAM ports ----------------
    logic                    src_wr_en, src_rd_en;
    logic [SAW-1:0]          src_wr_addr, src_rd_addr;
    logic [15:0]             src_rd_data;
    logic                    pyr_wr_en, pyr_rd_en;
    logic [PAW-1:0]          pyr_wr_addr, pyr_rd_addr;
    logic [15:0]             pyr_wr_data, pyr_rd_data;

    hmb_ram #(.WIDTH(16), .DEPTH(SRC_DEPTH)) u_src_ram (
        .clk     (clk),
        .wr_en   (src_wr_en),
        .wr_addr (src_wr_addr),
        .wr_data (s_axis_tdata[52:37]),
        .rd_en   (src_rd_en),
        .rd_addr (src_rd_addr),
        .rd_data (src_rd_data)
    );

    hmb_ram #(.WIDTH(16), .DEPTH(PYR_DEPTH)) u_pyr_ram (
        .clk     (clk),
        .wr_en   (pyr_wr_en),
        .wr_addr (pyr_wr_addr),
        .wr_data (pyr_wr_data),
        .rd_en   (pyr_rd_en),
        .rd_addr (pyr_rd_addr),
        .rd_data (pyr_rd_data)
    );

    // ---------------- request fields ----------------
    logic [1:0]  in_req;
    logic [7:0]  in_x, in_z;
    logic [8:0]  in_right, in_top;
    logic [2:0]  in_level;
    logic        in_accept;

    assign in_req    = s_axis_tuser[1:0];
    assign in_x      = s_axis_tdata[7:0];
    assign in_z      = s_axis_tdata[15:8];
    assign in_right  = s_axis_tdata[24:16];
    assign in_top    = s_axis_tdata[33:25];
    assign in_level  = s_axis_tdata[36:34];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Request side is open only when idle and the result slot is free or draining.
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_count_reg, out_height_reg};
    assign m_axis_tuser  = out_status_reg;

    // ---------------- map geometry ----------------
    logic [MW-1:0] m_eff;      // effective map size
    logic [3:0]    n_lvl;      // level count = floor(log2 m) for m >= 2
    logic [MW-1:0] top;        // level 0 side

    always_comb
    begin
        if (CW'(map_size_reg) > CW'(MAX_MAP_SIZE))
        begin
            m_eff = MW'(MAX_MAP_SIZE);
        end
        else
        begin
            m_eff = MW'(map_size_reg);
        end
        n_lvl = 4'd0;
        for (int k = 1; k < MW; k++)
        begin
            if (m_eff[k])
            begin
                n_lvl = 4'(k);
            end
        end
    end

    assign top = MW'(1) << n_lvl;

    // Texel read address. Level bases are sums of distinct powers of four, so the
    // base is simply a set of bits: 4^k for every k in (n - level, n].
    logic [RBW-1:0] rd_base;
    logic [MW-1:0]  rd_side;
    logic [3:0]     rd_shift;
    logic           rd_level_ok, rd_coord_ok;

    always_comb
    begin
        rd_base = '0;
        for (int k = 1; k <= MW; k++)
        begin
            if ((k <= int'(n_lvl)) && (k + int'(in_level) > int'(n_lvl)))
            begin
                rd_base[2 * k] = 1'b1;
            end
        end
    end

    assign rd_side     = top >> in_level;
    assign rd_shift    = n_lvl - {1'b0, in_level};
    assign rd_level_ok = {1'b0, in_level} < n_lvl;
    assign rd_coord_ok = (CW'(in_x) < CW'(rd_side)) && (CW'(in_z) < CW'(rd_side));

    logic load_ok, win_ok;
    assign load_ok = (CW'(in_x) < CW'(m_eff)) && (CW'(in_z) < CW'(m_eff));
    assign win_ok  = (n_lvl != 4'd0)
                  && (CW'(in_x) < CW'(in_right)) && (CW'(in_z) < CW'(in_top))
                  && (CW'(in_right) <= CW'(m_eff)) && (CW'(in_top) <= CW'(m_eff));

    // ---------------- shared multiplier ----------------
    logic [MA-1:0]    mul_a;
    logic [MB-1:0]    mul_b;
    logic [PW-1:0]    mul_p;
    logic [ONE_W-1:0] wx, wz;

    assign wx = k_reg[0] ? fx_reg : (ONE - fx_reg);
    assign wz = k_reg[1] ? fz_reg : (ONE - fz_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_L0X:
            begin
                mul_a = MA'(dx_reg);
                mul_b = MB'(m_eff);
            end
            ST_L0Z:
            begin
                mul_a = MA'(dz_reg);
                mul_b = MB'(m_eff);
            end
            ST_L0W:
            begin
                mul_a = MA'(wx);
                mul_b = MB'(wz);
            end
            ST_L0P:
            begin
                mul_a = prod_reg[MA-1:0];
                mul_b = MB'(src_rd_data);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Source position and fraction from the registered product d*m:
    // q = (d*m << F) >> n, src = min(q >> F, m-2), frac = min(q - src << F, one).
    logic [SXW-1:0]   pq, src_raw;
    logic [MW-1:0]    m_minus2, src_c;
    logic [XQW-1:0]   xq, frac_full;
    logic [ONE_W-1:0] frac_c;

    always_comb
    begin
        pq        = prod_reg[SXW-1:0];
        m_minus2  = m_eff - MW'(2);
        src_raw   = pq >> n_lvl;
        src_c     = (src_raw > SXW'(m_minus2)) ? m_minus2 : src_raw[MW-1:0];
        xq        = {pq, {FRAC_BITS{1'b0}}} >> n_lvl;
        frac_full = xq - {SXW'(src_c), {FRAC_BITS{1'b0}}};
        frac_c    = (frac_full > XQW'(ONE)) ? ONE : frac_full[ONE_W-1:0];
    end

    // ---------------- serial divider (window edges of level 0) ----------------
    logic [MW:0]     rem_shift;
    logic            rem_ge;
    logic [NUMW-1:0] div_load;
    logic [MW-1:0]   edge_lim;

    assign rem_shift = {rem_reg, div_num_reg[NUMW-1]};
    assign rem_ge    = rem_shift >= (MW+1)'(m_eff);
    // low edges floor(e*top/m), high edges ceil(e*top/m)
    assign div_load  = (NUMW'(win_reg[k_reg]) << n_lvl)
                     + (k_reg[1] ? NUMW'(m_eff - MW'(1)) : NUMW'(0));
    assign edge_lim  = k_reg[1] ? top : (top - MW'(1));

    // ---------------- texel addressing ----------------
    logic [PAW-1:0] wr_addr_lvl, par_addr;
    logic           last_x, last_z, last_lvl;

    assign wr_addr_lvl = base_reg + (PAW'(dz_reg) << slog_reg) + PAW'(dx_reg);
    assign par_addr    = pbase_reg + (PAW'({dz_reg, k_reg[1]}) << (slog_reg + 4'd1))
                       + PAW'({dx_reg, k_reg[0]});
    assign last_x      = (MW+1)'(dx_reg) + (MW+1)'(1) >= (MW+1)'(win_reg[WIN_R]);
    assign last_z      = (MW+1)'(dz_reg) + (MW+1)'(1) >= (MW+1)'(win_reg[WIN_T]);
    assign last_lvl    = (lvl_reg + 4'd1) == n_lvl;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        map_size_next   = map_size_reg;
        pyr_valid_next  = pyr_valid_reg;
        out_valid_next  = out_valid_reg;
        out_height_next = out_height_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        k_next          = k_reg;
        lvl_next        = lvl_reg;
        slog_next       = slog_reg;
        base_next       = base_reg;
        pbase_next      = pbase_reg;
        for (int i = 0; i < 4; i++)
        begin
            win_next[i] = win_reg[i];
        end
        dx_next         = dx_reg;
        dz_next         = dz_reg;
        sx_next         = sx_reg;
        sz_next         = sz_reg;
        fx_next         = fx_reg;
        fz_next         = fz_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        sum_next        = sum_reg;
        div_num_next    = div_num_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;

        src_wr_en   = 1'b0;
        src_wr_addr = SAW'(SAW'(in_z) * SAW'(MAX_MAP_SIZE) + SAW'(in_x));
        src_rd_en   = 1'b0;
        src_rd_addr = SAW'((SAW'(sz_reg) + SAW'(k_reg[1])) * SAW'(MAX_MAP_SIZE)
                    + SAW'(sx_reg) + SAW'(k_reg[0]));
        pyr_wr_en   = 1'b0;
        pyr_wr_addr = wr_addr_lvl;
        pyr_wr_data = acc_reg[2*FRAC_BITS +: 16];
        pyr_rd_en   = 1'b0;
        pyr_rd_addr = par_addr;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            map_size_next  = cfg_wr_data;
            pyr_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    out_count_next  = n_lvl;
                    out_height_next = 16'd0;
                    out_status_next = hmb_pkg::STATUS_OK;
                    out_valid_next  = 1'b1;
                    unique case (in_req)
                        hmb_pkg::REQ_LOAD:
                        begin
                            if (load_ok)
                            begin
                                src_wr_en = 1'b1;
                            end
                            else
                            begin
                                out_status_next = hmb_pkg::STATUS_RANGE;
                            end
                        end
                        hmb_pkg::REQ_REBUILD:
                        begin
                            if (win_ok)
                            begin
                                out_valid_next  = 1'b0;
                                win_next[WIN_L] = MW'(in_x);
                                win_next[WIN_B] = MW'(in_z);
                                win_next[WIN_R] = MW'(in_right);
                                win_next[WIN_T] = MW'(in_top);
                                k_next          = 2'd0;
                                lvl_next        = 4'd0;
                                slog_next       = n_lvl;
                                base_next       = '0;
                                pbase_next      = '0;
                                state_next      = ST_DLD;
                            end
                            else
                            begin
                                out_status_next = hmb_pkg::STATUS_WINDOW;
                            end
                        end
                        hmb_pkg::REQ_READ:
                        begin
                            if (!rd_level_ok || !rd_coord_ok)
                            begin
                                out_status_next = hmb_pkg::STATUS_RANGE;
                            end
                            else if (!pyr_valid_reg)
                            begin
                                out_status_next = hmb_pkg::STATUS_NOT_BUILT;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                pyr_rd_en      = 1'b1;
                                pyr_rd_addr    = PAW'(rd_base) + (PAW'(in_z) << rd_shift)
                                               + PAW'(in_x);
                                state_next     = ST_RDW;
                            end
                        end
                        default:
                        begin
                            out_status_next = hmb_pkg::STATUS_RANGE;
                        end
                    endcase
                end
            end
            ST_RDW:
            begin
                out_height_next = pyr_rd_data;
                out_valid_next  = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_DLD:
            begin
                div_num_next = div_load;
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_DIT;
            end
            ST_DIT:
            begin
                rem_next     = rem_ge ? MW'(rem_shift - (MW+1)'(m_eff)) : MW'(rem_shift);
                div_num_next = {div_num_reg[NUMW-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(NUMW - 1))
                begin
                    state_next = ST_DST;
                end
            end
            ST_DST:
            begin
                win_next[k_reg] = (div_num_reg > NUMW'(edge_lim)) ? edge_lim
                                                                  : div_num_reg[MW-1:0];
                k_next = k_reg + 2'd1;
                if (k_reg == WIN_T)
                begin
                    dx_next    = win_reg[WIN_L];
                    dz_next    = win_reg[WIN_B];
                    state_next = ST_L0X;
                end
                else
                begin
                    state_next = ST_DLD;
                end
            end
            ST_L0X:
            begin
                prod_next  = mul_p;
                state_next = ST_L0Z;
            end
            ST_L0Z:
            begin
                sx_next    = src_c;
                fx_next    = frac_c;
                prod_next  = mul_p;
                state_next = ST_L0F;
            end
            ST_L0F:
            begin
                sz_next    = src_c;
                fz_next    = frac_c;
                state_next = ST_L0W;
            end
            ST_L0W:
            begin
                prod_next  = mul_p;
                src_rd_en  = 1'b1;
                state_next = ST_L0P;
            end
            ST_L0P:
            begin
                prod_next  = mul_p;
                state_next = ST_L0A;
            end
            ST_L0A:
            begin
                acc_next   = ((k_reg == 2'd0) ? ACCW'(0) : acc_reg) + ACCW'(prod_reg);
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? ST_L0WR : ST_L0W;
            end
            ST_HRD:
            begin
                pyr_rd_en  = 1'b1;
                state_next = ST_HAC;
            end
            ST_HAC:
            begin
                sum_next   = ((k_reg == 2'd0) ? 18'd0 : sum_reg) + 18'(pyr_rd_data);
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? ST_HWR : ST_HRD;
            end
            ST_L0WR, ST_HWR:
            begin
                pyr_wr_en = 1'b1;
                if (state_reg == ST_HWR)
                begin
                    pyr_wr_data = sum_reg[17:2];
                end
                // advance along the row, then the column, then the level
                if (!last_x)
                begin
                    dx_next    = dx_reg + MW'(1);
                    state_next = (lvl_reg == 4'd0) ? ST_L0X : ST_HRD;
                end
                else if (!last_z)
                begin
                    dx_next    = win_reg[WIN_L];
                    dz_next    = dz_reg + MW'(1);
                    state_next = (lvl_reg == 4'd0) ? ST_L0X : ST_HRD;
                end
                else if (last_lvl)
                begin
                    pyr_valid_next  = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    // next level window: floor of the low edges, ceil of the high ones
                    win_next[WIN_L] = win_reg[WIN_L] >> 1;
                    win_next[WIN_B] = win_reg[WIN_B] >> 1;
                    win_next[WIN_R] = MW'(((MW+1)'(win_reg[WIN_R]) + (MW+1)'(1)) >> 1);
                    win_next[WIN_T] = MW'(((MW+1)'(win_reg[WIN_T]) + (MW+1)'(1)) >> 1);
                    dx_next         = win_reg[WIN_L] >> 1;
                    dz_next         = win_reg[WIN_B] >> 1;
                    pbase_next      = base_reg;
                    base_next       = base_reg + (PAW'(1) << {slog_reg, 1'b0});
                    slog_next       = slog_reg - 4'd1;
                    lvl_next        = lvl_reg + 4'd1;
                    state_next      = ST_HRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            map_size_reg  <= hmb_pkg::MAP_SIZE_RESET;
            pyr_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= 2'd0;
            lvl_reg       <= 4'd0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            map_size_reg  <= map_size_next;
            pyr_valid_reg <= pyr_valid_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            lvl_reg       <= lvl_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        out_height_reg <= out_height_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        slog_reg       <= slog_next;
        base_reg       <= base_next;
        pbase_reg      <= pbase_next;
        for (int i = 0; i < 4; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        dx_reg         <= dx_next;
        dz_reg         <= dz_next;
        sx_reg         <= sx_next;
        sz_reg         <= sz_next;
        fx_reg         <= fx_next;
        fz_reg         <= fz_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        sum_reg        <= sum_next;
        div_num_reg    <= div_num_next;
        rem_reg        <= rem_next;
    end

    // ---------------- checks ----------------
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !pyr_valid_reg)
        else $error("pyramid still valid after map_size write");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != hmb_pkg::STATUS_OK))
        |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("nonzero height on failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        pyr_wr_en |-> (lvl_reg < n_lvl))
        else $error("pyramid write beyond last level");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIT) |-> (div_cnt_reg < DCW'(NUMW)))
        else $error("divider ran past its step count");

endmodule

`default_nettype wire

/* rtl/core/hmb_ram.sv */
// hmb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module hmb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
